// File: rtl/core/eqrs_pkg.sv
// Package: shared types, constants and controller states for the QRS detector.
`timescale 1ns / 1ps
package eqrs_pkg;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 20;
  localparam logic [15:0] VPL_RESET = 16'd16777;
  localparam logic [63:0] HOLDOFF_NS = 64'd300000000;
  localparam logic [63:0] GAP_MAX_NS = 64'd2000000000;
  localparam logic [63:0] BPM_NUM    = 64'd15360000000000;
  localparam logic [15:0] RATE_LOW   = 16'd7680;
  localparam logic [15:0] RATE_HIGH  = 16'd61440;
  localparam int CFG_VPL = 0;
  localparam int CFG_LDE = 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCALE, ST_BASE, ST_BASE2, ST_HP, ST_THR, ST_PEAK, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic scale;
    logic base;
    logic base2;
    logic hp;
    logic thr;
    logic peak;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic div_needed;
    logic div_done;
  } sts_t;
endpackage

// File: rtl/core/eqrs_ctrl.sv
// Controller: sequences the datapath steps for one sample.
`timescale 1ns / 1ps
module eqrs_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic out_busy,
  input  eqrs_pkg::sts_t sts,
  output eqrs_pkg::cmd_t cmd,
  output logic idle
);
  import eqrs_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    idle = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_SCALE;
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = sts.ok ? ST_BASE : ST_OUT;
      end
      ST_BASE:  begin cmd.base = 1'b1;  state_nxt = ST_BASE2; end
      ST_BASE2: begin cmd.base2 = 1'b1; state_nxt = ST_HP; end
      ST_HP:    begin cmd.hp = 1'b1;    state_nxt = ST_PEAK; end
      // peak test sees the threshold and previous high-pass of the last sample
      ST_PEAK: begin
        cmd.peak = 1'b1;
        cmd.div_start = sts.div_needed;
        state_nxt = ST_THR;
      end
      ST_THR: begin
        cmd.thr = 1'b1;
        state_nxt = sts.div_done ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: if (!out_busy) begin
        cmd.finish = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// File: rtl/core/eqrs_dp.sv
// Datapath: scaling, lead-off status, baseline, high-pass, threshold, quality, peak timing and rate divider.
`timescale 1ns / 1ps
module eqrs_dp #(
  parameter int SAMPLE_WIDTH = eqrs_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = eqrs_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic signed [SAMPLE_WIDTH-1:0] raw_sample,
  input  logic adc_read_ok,
  input  logic [63:0] sample_time,
  input  logic lead_off_minus,
  input  logic lead_off_plus,
  input  logic lead_read_ok,
  input  logic [15:0] volt_per_lsb,
  input  logic lead_detect_enable,
  input  eqrs_pkg::cmd_t cmd,
  output eqrs_pkg::sts_t sts,
  output logic [15:0] heart_rate,
  output logic [15:0] quality,
  output logic rate_valid,
  output logic leads_connected
);
  import eqrs_pkg::*;
  localparam int SH = 28 - FRAC_BITS;
  localparam int PW = SAMPLE_WIDTH + 17;
  localparam logic signed [63:0] V_50TH = (64'sd1 <<< FRAC_BITS) / 50 +
    (((64'sd1 <<< FRAC_BITS) % 50) >= 25 ? 1 : 0);
  localparam logic signed [63:0] V_1P5 = (64'sd3 <<< FRAC_BITS) / 2 +
    (((64'sd3 <<< FRAC_BITS) % 2) >= 1 ? 1 : 0);
  localparam logic signed [31:0] THR_RST = 32'(((64'sd1 <<< FRAC_BITS) + 2) / 5);
  localparam logic signed [63:0] V_TEN = ((64'sd1 <<< FRAC_BITS) + 5) / 10;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sd2147483647;
    if (v < -64'sd2147483647) return -32'sd2147483647;
    return v[31:0];
  endfunction

  // round to nearest, ties up: (v + half) >>> s
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  logic signed [SAMPLE_WIDTH-1:0] raw_r;
  logic ok_r, lmin_r, lplus_r, lok_r;
  logic [63:0] t_r;
  logic signed [31:0] base_r, prev_r, thr_r, volts_r, hp_r;
  logic signed [63:0] diff_r;
  logic [63:0] last_r;
  logic [15:0] rate_r, qual_r;
  logic leads_r, valid_r;
  logic [63:0] rem_r, dsh_r;
  logic [15:0] quo_r, quo_nxt;
  logic [4:0] cnt_r;

  logic signed [PW-1:0] prod;
  logic signed [63:0] amp, tgt, bl;
  logic [63:0] gap;
  logic peak, in_band, div_ge;
  logic [15:0] q_nxt;

  assign prod = PW'(raw_r) * $signed({1'b0, volt_per_lsb});
  assign gap = t_r - last_r;
  assign peak = (hp_r > thr_r) && (hp_r > prev_r) && ((last_r == 64'd0) || gap > HOLDOFF_NS);
  assign in_band = (last_r != 64'd0) && gap > HOLDOFF_NS && gap < GAP_MAX_NS;
  assign amp = hp_r[31] ? -64'(hp_r) : 64'(hp_r);
  assign bl = (base_r == 32'sd0) ? 64'(volts_r) : 64'(base_r);
  assign div_ge = (rem_r >= dsh_r);
  assign quo_nxt = {quo_r[14:0], div_ge};

  always_comb begin
    tgt = rnd(amp * 64'sd29491, 14);
    if (tgt > 64'sd2147483647) tgt = 64'sd2147483647;
    if (tgt < V_TEN) tgt = V_TEN;
    if (amp < V_50TH) q_nxt = 16'd0;
    else if (amp < V_TEN) q_nxt = 16'(rnd(amp * 64'sd327680, FRAC_BITS));
    else if (amp <= V_1P5) q_nxt = 16'd32768;
    else q_nxt = 16'd0;
  end

  assign sts.ok = ok_r;
  assign sts.div_needed = peak && in_band;
  assign sts.div_done = (cnt_r == 5'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0; prev_r <= '0; thr_r <= THR_RST; last_r <= '0;
      rate_r <= '0; leads_r <= 1'b1; qual_r <= '0; valid_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (in_fire) begin
        raw_r <= raw_sample; ok_r <= adc_read_ok; t_r <= sample_time;
        lmin_r <= lead_off_minus; lplus_r <= lead_off_plus; lok_r <= lead_read_ok;
        valid_r <= 1'b0;
      end
      if (cmd.scale) begin
        volts_r <= sat32(rnd(64'(prod), SH));
        if (ok_r && lead_detect_enable) leads_r <= lok_r && !lmin_r && !lplus_r;
      end
      if (cmd.base) begin
        base_r <= bl[31:0];
        diff_r <= (64'(volts_r) - bl) * 64'sd131;
      end
      if (cmd.base2) base_r <= sat32(64'(base_r) + rnd(diff_r, 16));
      if (cmd.hp) hp_r <= sat32(64'(volts_r) - 64'(base_r));
      if (cmd.peak && peak) last_r <= t_r;
      if (cmd.thr) begin
        thr_r <= sat32(rnd(64'(thr_r) * 64'sd64881 + tgt * 64'sd655, 16));
        qual_r <= q_nxt;
        prev_r <= hp_r;
      end
      // rate = (num + gap/2) / gap; gap lies in (0.3 s, 2 s) so 16 quotient bits suffice
      if (cmd.div_start) begin
        rem_r <= BPM_NUM + (gap >> 1);
        dsh_r <= gap << 15;
        quo_r <= '0;
        cnt_r <= 5'd16;
      end
      // restoring divide, one quotient bit a cycle
      if (cmd.div_step && cnt_r != 5'd0) begin
        if (div_ge) rem_r <= rem_r - dsh_r;
        dsh_r <= dsh_r >> 1;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) rate_r <= quo_nxt;
      end
      if (cmd.finish) valid_r <= ok_r && qual_r != 16'd0 && rate_r >= RATE_LOW &&
        rate_r <= RATE_HIGH && (!lead_detect_enable || (lok_r && leads_r));
    end
  end

  assign heart_rate = rate_r;
  assign quality = qual_r;
  assign rate_valid = valid_r;
  assign leads_connected = leads_r;
endmodule

// File: rtl/core/ecg_qrs_heart_rate_detector.sv
// Top level of the ECG QRS peak and heart-rate detector.
// One sample per transfer, one result per sample. After an input transfer the
// controller steps through scale multiply, two baseline steps, high-pass, peak
// test, threshold update and, when a new rate is formed, the divider, which forms
// the 16 quotient bits one at a time; a failed converter read goes from the scale
// step straight to the output. in_tready is high only while the controller is idle
// and no result waits, so the block takes no new sample until the last result has
// been taken. Configuration registers are written through cfg_*; the user must
// write them only while the block is idle, as the block itself does not enforce it.
`timescale 1ns / 1ps
module ecg_qrs_heart_rate_detector #(
  parameter int SAMPLE_WIDTH = eqrs_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = eqrs_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // tdata: raw_sample, adc_read_ok, sample_time, lead_off_minus, lead_off_plus, lead_read_ok
  input  logic [((SAMPLE_WIDTH + 68 + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // tdata: heart_rate, quality, rate_valid, leads_connected
  output logic [39:0] out_tdata,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [15:0] cfg_wdata
);
  import eqrs_pkg::*;
  localparam int S = SAMPLE_WIDTH;
  cmd_t cmd;
  sts_t sts;
  logic idle, in_fire;
  logic [15:0] vpl_r, hr, q;
  logic lde_r, rv, lc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpl_r <= VPL_RESET; lde_r <= 1'b0; out_tvalid <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == 1'(CFG_VPL)) vpl_r <= cfg_wdata;
      if (cfg_we && cfg_index == 1'(CFG_LDE)) lde_r <= cfg_wdata[0];
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (cmd.finish) out_tvalid <= 1'b1;
    end
  end

  // result fields live in the datapath registers, so hold input until it is taken
  assign in_tready = idle && !out_tvalid;
  assign in_fire = in_tvalid && in_tready;
  assign out_tdata = {6'd0, lc, rv, q, hr};

  eqrs_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(out_tvalid && !out_tready), .sts, .cmd, .idle
  );

  eqrs_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .in_fire,
    .raw_sample(in_tdata[S-1:0]), .adc_read_ok(in_tdata[S]),
    .sample_time(in_tdata[S+64:S+1]), .lead_off_minus(in_tdata[S+65]),
    .lead_off_plus(in_tdata[S+66]), .lead_read_ok(in_tdata[S+67]),
    .volt_per_lsb(vpl_r), .lead_detect_enable(lde_r), .cmd, .sts,
    .heart_rate(hr), .quality(q), .rate_valid(rv), .leads_connected(lc)
  );
endmodule

// File: rtl/core/eqrs_checker.sv
// Port-level checker for the detector, bound to the top level.
`timescale 1ns / 1ps
module eqrs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [39:0] out_tdata
);
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid) else $error("result too early");
  a_valid_lo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[31:16] != 16'd0)
    else $error("rate valid with zero quality");
endmodule

bind ecg_qrs_heart_rate_detector eqrs_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
